FILE: hw/rtl/erp_pkg.sv
// Shared types and constants for the elevation record parser.
// Result codes, phase encoding, configuration indexes and the result bundle.
// No dependencies.
package erp_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned POS_W    = 13;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned CFG_W    = 13;
    localparam int unsigned SHIFT_W  = 24;

    // Default for the saturation width of reported positions
    localparam int unsigned INDEX_BITS_DEF = 13;

    // Register reset values
    localparam logic [POS_W-1:0]  PROFILE_POINTS_RST   = 13'd1201;
    localparam logic [BYTE_W-1:0] RECOGNITION_BYTE_RST = 8'd170;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_PROFILE_POINTS   = 1'b0,
        CFG_RECOGNITION_BYTE = 1'b1
    } t_cfg_index;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    // Record end status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RECOG = 2'd1,
        ST_BAD_SUM   = 2'd2
    } t_status;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_SAMPLES = 3'b010,
        PH_TRAILER = 3'b100
    } t_phase;

    // Byte counts that close the header and trailer phases
    localparam logic [CNT_W-1:0] HDR_LAST_BYTE = 3'd7;
    localparam logic [CNT_W-1:0] TRL_LAST_BYTE = 3'd3;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    position;
        t_status             status;
        logic                last;
    } t_result;

    // 16-bit sign-magnitude to two's complement; negative zero reads as zero
    function automatic logic [VALUE_W-1:0] sm16_to_tc(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        mag = {1'b0, raw[VALUE_W-2:0]};
        return raw[VALUE_W-1] ? (~mag + 16'd1) : mag;
    endfunction

endpackage

FILE: hw/rtl/elevation_record_parser_core.sv
// Elevation record parser, top level.
// Parses header, samples and checksum trailer of one record per byte.
// Depends on erp_pkg.

// Takes one record byte per transaction, one byte per clock sustained while
// the skid entry is empty; each byte is handled by one short update
// between the input handshake and a result register. An 8-byte header
// (recognition byte, 3-byte block count, column, start row, sign-magnitude
// big-endian) yields a header result with the column and the start row
// (negative rows clamp to zero, positions saturate at 2^P_INDEX_BITS-1).
// Each 2-byte sample from the start row up to profile_points-1 yields a
// sample result, and the 4-byte trailer yields a record end result with the
// checksum status. A wrong recognition byte ends the record right after the
// header with status bad recognition. Results pass through an output
// register backed by one skid entry, so input is held off only when both
// are full. Configuration writes are accepted in every cycle and are meant
// to happen while the block is idle.
module elevation_record_parser_core
    import erp_pkg::*;
#(
    parameter int unsigned P_INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // byte input channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [BYTE_W-1:0]          i_data_byte,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [KIND_W-1:0]          o_kind,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic [POS_W-1:0]           o_position,
    output logic [STATUS_W-1:0]        o_status,
    output logic                       o_last,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [0:0]                 i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    localparam int unsigned SAT_W = VALUE_W + 1;
    localparam logic [SAT_W-1:0] L_IDX_MAX = SAT_W'((32'd1 << P_INDEX_BITS) - 32'd1);

    // Clamp a position to the index range, then to the port width
    function automatic logic [POS_W-1:0] sat_pos(input logic [SAT_W-1:0] v);
        return (v > L_IDX_MAX) ? L_IDX_MAX[POS_W-1:0] : v[POS_W-1:0];
    endfunction

    // Configuration registers
    logic [POS_W-1:0]   r_profile_points;
    logic [BYTE_W-1:0]  r_recog_byte;

    // Parser state
    t_phase             r_phase,   n_phase;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [POS_W-1:0]   r_row,     n_row;
    logic [SUM_W-1:0]   r_sum,     n_sum;
    logic [SHIFT_W-1:0] r_shift,   n_shift;
    logic [BYTE_W-1:0]  r_first,   n_first;

    // Output register and skid entry
    logic               r_out_vld;
    t_result            r_out;
    logic               r_skid_vld;
    t_result            r_skid;

    logic               in_fire;
    logic               out_fire;
    logic               res_vld;
    t_result            res;

    assign o_ready     = ~r_skid_vld;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_valid & o_ready;
    assign out_fire    = r_out_vld & i_ready;

    assign o_valid    = r_out_vld;
    assign o_kind     = r_out.kind;
    assign o_value    = r_out.value;
    assign o_position = r_out.position;
    assign o_status   = r_out.status;
    assign o_last     = r_out.last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_points <= PROFILE_POINTS_RST;
            r_recog_byte     <= RECOGNITION_BYTE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PROFILE_POINTS:   r_profile_points <= i_cfg_data[POS_W-1:0];
                CFG_RECOGNITION_BYTE: r_recog_byte     <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-byte parse step
    always_comb begin
        logic [VALUE_W-1:0]  raw16;
        logic [VALUE_W-1:0]  row16;
        logic [SUM_W-1:0]    trailer;
        logic                sum_ok;
        logic [POS_W:0]      next_row;

        n_phase = r_phase;
        n_count = r_count;
        n_row   = r_row;
        n_sum   = r_sum;
        n_shift = r_shift;
        n_first = r_first;
        res_vld = 1'b0;
        res     = '{kind: KIND_HEADER, value: '0, position: '0, status: ST_OK, last: 1'b0};

        raw16    = {r_shift[BYTE_W-1:0], i_data_byte};
        row16    = raw16[VALUE_W-1] ? '0 : raw16;
        trailer  = {r_shift, i_data_byte};
        next_row = {1'b0, r_row} + 14'd1;
        sum_ok   = trailer[SUM_W-1] ? ((trailer[SUM_W-2:0] == '0) && (r_sum == '0))
                                    : ({1'b0, trailer[SUM_W-2:0]} == r_sum);

        if (in_fire) begin
            n_shift = {r_shift[SHIFT_W-BYTE_W-1:0], i_data_byte};
            case (r_phase)
                PH_SAMPLES: begin
                    n_sum = r_sum + {{(SUM_W-BYTE_W){1'b0}}, i_data_byte};
                    if (r_count == '0) begin
                        n_count = 3'd1;
                    end else begin
                        n_count = '0;
                        res_vld = 1'b1;
                        res.kind     = KIND_SAMPLE;
                        res.value    = sm16_to_tc(raw16);
                        res.position = sat_pos({{(SAT_W-POS_W){1'b0}}, r_row});
                        n_row = next_row[POS_W-1:0];
                        if (next_row >= {1'b0, r_profile_points}) begin
                            n_phase = PH_TRAILER;
                        end
                    end
                end
                PH_TRAILER: begin
                    if (r_count != TRL_LAST_BYTE) begin
                        n_count = r_count + 3'd1;
                    end else begin
                        n_count = '0;
                        n_phase = PH_HEADER;
                        res_vld = 1'b1;
                        res.kind   = KIND_END;
                        res.status = sum_ok ? ST_OK : ST_BAD_SUM;
                        res.last   = 1'b1;
                    end
                end
                default: begin
                    // header phase, also any stray phase code
                    n_phase = PH_HEADER;
                    n_sum   = ((r_count == '0) ? '0 : r_sum)
                            + {{(SUM_W-BYTE_W){1'b0}}, i_data_byte};
                    if (r_count == '0) begin
                        n_first = i_data_byte;
                    end
                    if (r_count != HDR_LAST_BYTE) begin
                        n_count = r_count + 3'd1;
                    end else begin
                        n_count = '0;
                        res_vld = 1'b1;
                        if (r_first != r_recog_byte) begin
                            res.kind   = KIND_END;
                            res.status = ST_BAD_RECOG;
                            res.last   = 1'b1;
                        end else begin
                            res.kind     = KIND_HEADER;
                            res.value    = sm16_to_tc(r_shift[SHIFT_W-1:BYTE_W]);
                            res.position = sat_pos({1'b0, row16});
                            if (row16 >= {{(VALUE_W-POS_W){1'b0}}, r_profile_points}) begin
                                n_phase = PH_TRAILER;
                                n_row   = '0;
                            end else begin
                                n_phase = PH_SAMPLES;
                                n_row   = row16[POS_W-1:0];
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_row   <= '0;
            r_sum   <= '0;
            r_shift <= '0;
            r_first <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_row   <= n_row;
            r_sum   <= n_sum;
            r_shift <= n_shift;
            r_first <= n_first;
        end
    end

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_fire) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (res_vld) begin
            if (r_out_vld && !out_fire) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_vld <= 1'b0;
        end
    end

    // Payload moves; no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (res_vld) begin
            if (r_out_vld && !out_fire) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

endmodule
